// File: rtl/glmf_pkg.sv
// ----------------------------------------------------------------------------
// glmf_pkg
// shared widths, codes and register indices for the grid local maximum finder
// ----------------------------------------------------------------------------
`default_nettype none

package glmf_pkg;

    localparam int MAX_COLS      = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int COL_BITS      = $clog2(MAX_COLS);
    localparam int ROW_BITS      = 12;
    localparam int CFG_COLS_BITS = 11;
    localparam int CFG_DATA_BITS = 12;
    localparam int PEAK_COL_BITS = 10;
    localparam int OUT_RAW_BITS  = ROW_BITS + PEAK_COL_BITS;
    localparam int OUT_BITS      = ((OUT_RAW_BITS + 7) / 8) * 8;
    localparam int IN_BITS       = ((SAMPLE_BITS + 7) / 8) * 8;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef enum logic [0:0]
    {
        REG_GRID_ROWS = 1'b0,
        REG_GRID_COLS = 1'b1
    } cfg_reg_t;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

`default_nettype wire

// File: rtl/grid_local_maximum_finder.sv
// ----------------------------------------------------------------------------
// grid_local_maximum_finder
// four-neighbour peak detection over a row-major sample stream
// ----------------------------------------------------------------------------
// input stream: tuser is the command (sample or flush tick), tdata the signed
// sample. samples of one frame arrive row by row; cell (r-1,c) is decided when
// sample (r,c) is taken, and the last row is decided by one flush tick per
// column after the frame. samples during flushing and flush ticks during
// loading are dropped without a result.
// output stream: one transaction per peak, row and column in tdata, in
// row-major order. a peak is registered into the output register, or the skid
// entry while that is held, when the item that decides it is taken. throughput
// is one item per clock while tready is high: the recent line buffer is read
// one address ahead of the current column, the older one at it, so every item
// finds its neighbours registered. a two-entry output buffer lets input go on
// while a result waits; input tready falls only when both entries are full.
// configuration: cfg_index selects grid_rows (0) or grid_cols (1); a write
// takes effect at once and restarts the frame. line buffers keep contents.
// reset clears positions, the output buffer and sets both dimensions to two;
// the line buffers need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_local_maximum_finder
    import glmf_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,

    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    input  wire logic [IN_BITS-1:0]       s_axis_tdata,   // sample
    input  wire logic                     s_axis_tuser,   // cmd

    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    output logic      [OUT_BITS-1:0]      m_axis_tdata,   // peak_row, peak_col, zero pad

    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [0:0]               cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    // configuration
    logic [ROW_BITS-1:0]      grid_rows_reg;
    logic [CFG_COLS_BITS-1:0] grid_cols_reg;
    logic [ROW_BITS-1:0]      rows_eff;
    logic [CFG_COLS_BITS-1:0] cols_eff;
    logic                     cfg_fire;

    // position
    logic [ROW_BITS-1:0] row_pos_reg;
    logic [ROW_BITS-1:0] row_pos_next;
    logic [COL_BITS-1:0] col_pos_reg;
    logic [COL_BITS-1:0] col_pos_next;
    logic                loaded_reg;
    logic                loaded_next;
    logic                col_last;
    logic                row_last;

    // window
    sample_t first_reg;
    sample_t hold_reg;
    sample_t left_reg;
    sample_t fwd_data_reg;
    logic    fwd_valid_reg;
    sample_t sample_in;
    sample_t center;
    sample_t right_val;
    sample_t up_val;
    logic [SAMPLE_BITS-1:0] rec_rdata;
    logic [SAMPLE_BITS-1:0] old_rdata;
    logic [COL_BITS-1:0]    rec_raddr;
    logic                   rec_we;
    logic                   old_we;

    // item handling
    logic                in_fire;
    logic                act;
    logic                is_flush;
    logic                found;
    logic [ROW_BITS-1:0] peak_row;

    // output buffer
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUT_BITS-1:0]     out_data_reg;
    logic [OUT_BITS-1:0]     out_data_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic [OUT_BITS-1:0]     skid_data_reg;
    logic [OUT_BITS-1:0]     skid_data_next;
    logic [OUT_BITS-1:0]     new_data;
    logic                    out_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign rows_eff = (grid_rows_reg < ROW_BITS'(2)) ? ROW_BITS'(2) : grid_rows_reg;

    always_comb
    begin
        cols_eff = grid_cols_reg;
        if (grid_cols_reg < CFG_COLS_BITS'(2))
        begin
            cols_eff = CFG_COLS_BITS'(2);
        end
        else if (grid_cols_reg > CFG_COLS_BITS'(MAX_COLS))
        begin
            cols_eff = CFG_COLS_BITS'(MAX_COLS);
        end
    end

    assign col_last = (CFG_COLS_BITS'(col_pos_reg) == (cols_eff - CFG_COLS_BITS'(1)));
    assign row_last = (row_pos_reg == (rows_eff - ROW_BITS'(1)));

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign is_flush      = loaded_reg;
    assign act           = in_fire && ((s_axis_tuser == CMD_FLUSH) == loaded_reg);
    assign sample_in     = sample_t'(s_axis_tdata[SAMPLE_BITS-1:0]);

    // neighbour window
    assign center    = (col_pos_reg == '0) ? first_reg : hold_reg;
    assign right_val = fwd_valid_reg ? fwd_data_reg : sample_t'(rec_rdata);
    assign up_val    = sample_t'(old_rdata);

    always_comb
    begin
        found = 1'b1;
        if (!is_flush)
        begin
            if (row_pos_reg == '0)
            begin
                found = 1'b0;
            end
            if (center < sample_in)
            begin
                found = 1'b0;
            end
            if ((row_pos_reg >= ROW_BITS'(2)) && (center < up_val))
            begin
                found = 1'b0;
            end
        end
        else if (center < up_val)
        begin
            found = 1'b0;
        end
        if ((col_pos_reg != '0) && (center < left_reg))
        begin
            found = 1'b0;
        end
        if (!col_last && (center < right_val))
        begin
            found = 1'b0;
        end
    end

    assign peak_row = is_flush ? (rows_eff - ROW_BITS'(1)) : (row_pos_reg - ROW_BITS'(1));
    assign new_data = OUT_BITS'({PEAK_COL_BITS'(col_pos_reg), peak_row});

    // position update
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        loaded_next  = loaded_reg;
        if (cfg_fire)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
            loaded_next  = 1'b0;
        end
        else if (act)
        begin
            if (col_last)
            begin
                col_pos_next = '0;
                if (is_flush)
                begin
                    loaded_next = 1'b0;
                end
                else if (row_last)
                begin
                    row_pos_next = '0;
                    loaded_next  = 1'b1;
                end
                else
                begin
                    row_pos_next = row_pos_reg + ROW_BITS'(1);
                end
            end
            else
            begin
                col_pos_next = col_pos_reg + COL_BITS'(1);
            end
        end
    end

    // line buffers, recent read one column ahead, older at the current column
    assign rec_we    = act && !is_flush;
    assign old_we    = act && !is_flush && (row_pos_reg != '0);
    assign rec_raddr = col_pos_next + COL_BITS'(1);

    glmf_ram
    #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    )
    u_recent_ram
    (
        .clk   (clk),
        .we    (rec_we),
        .waddr (col_pos_reg),
        .wdata (sample_in),
        .raddr (rec_raddr),
        .rdata (rec_rdata)
    );

    glmf_ram
    #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_COLS)
    )
    u_older_ram
    (
        .clk   (clk),
        .we    (old_we),
        .waddr (col_pos_reg),
        .wdata (center),
        .raddr (col_pos_next),
        .rdata (old_rdata)
    );

    // output buffer
    assign out_fire = out_valid_reg && m_axis_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (act && found)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_valid_next = 1'b1;
                out_data_next  = new_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = new_data;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg  <= ROW_BITS'(2);
            grid_cols_reg  <= CFG_COLS_BITS'(2);
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            loaded_reg     <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_GRID_ROWS: grid_rows_reg <= cfg_data[ROW_BITS-1:0];
                    REG_GRID_COLS: grid_cols_reg <= cfg_data[CFG_COLS_BITS-1:0];
                    default:       grid_rows_reg <= grid_rows_reg;
                endcase
            end
            row_pos_reg    <= row_pos_next;
            col_pos_reg    <= col_pos_next;
            loaded_reg     <= loaded_next;
            fwd_valid_reg  <= rec_we && (col_pos_reg == rec_raddr);
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        fwd_data_reg  <= sample_in;
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
        if (act)
        begin
            hold_reg <= right_val;
            left_reg <= center;
            if (!is_flush && (col_pos_reg == '0))
            begin
                first_reg <= sample_in;
            end
        end
    end

`ifndef ASSERT_OFF

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    assert property (@(posedge clk) disable iff (!rst_n)
        CFG_COLS_BITS'(col_pos_reg) < cols_eff)
        else $error("column position beyond grid width");

    assert property (@(posedge clk) disable iff (!rst_n)
        loaded_reg |-> (row_pos_reg == '0))
        else $error("row position not cleared while flushing");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rec_we || old_we) |-> !loaded_reg)
        else $error("line buffer written during flush");

    assert property (@(posedge clk) disable iff (!rst_n)
        (act && found && !skid_valid_reg) |=> out_valid_reg)
        else $error("peak lost on the way to the output");

`endif

endmodule

`default_nettype wire

// File: rtl/glmf_ram.sv
// ----------------------------------------------------------------------------
// glmf_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module glmf_ram
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives row-major frames and flush ticks into the grid local maximum finder
// and checks every reported peak, in order, against a cycle-free tracker of
// the two line stores and the frame position. frames of random size and
// content, broken frames, stray items, register writes between phases and
// random stalls on both streams, including one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import glmf_pkg::*;

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int RANDOM_ITEMS  = 1550;
    localparam int WIDE_CUT      = 1040;
    localparam int TAIL_ITEMS    = 48;
    localparam int LATENCY_PAD   = 4;
    localparam int END_PAD       = 20;
    localparam int LONG_HOLD     = 300;
    localparam int MAX_IDLE      = 16;
    localparam int MAX_MISMATCH  = 10;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed
    {
        logic [ROW_BITS-1:0]      row;
        logic [PEAK_COL_BITS-1:0] col;
    } peak_t;

    typedef struct packed
    {
        logic    cmd;
        sample_t value;
        logic    drain;
    } stream_item_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_BITS-1:0]       s_axis_tdata;   // sample
    logic                     s_axis_tuser;   // cmd
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_BITS-1:0]      m_axis_tdata;   // peak_row, peak_col, zero pad
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [0:0]               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    // tracked block state
    sample_t                  upper_line [MAX_COLS];
    sample_t                  lower_line [MAX_COLS];
    logic [ROW_BITS-1:0]      cur_row;
    logic [COL_BITS-1:0]      cur_col;
    logic [CFG_COLS_BITS-1:0] flush_col;
    logic                     loaded;
    logic [ROW_BITS-1:0]      rows_reg;
    logic [CFG_COLS_BITS-1:0] cols_reg;

    peak_t        due_peaks [$];
    stream_item_t item_q [$];
    stream_item_t cur_item;

    bit in_took;
    bit out_took;
    bit quiet;
    bit long_hold_req;
    int gap_left;
    int rx_gap;
    int hold_left;
    int fail_count;
    int cycle_count;
    int frame_items;

    grid_local_maximum_finder dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int rows_eff();
        return (rows_reg < 2) ? 2 : int'(rows_reg);
    endfunction

    function automatic int cols_eff();
        int c;
        c = int'(cols_reg);
        if (c < 2)
            c = 2;
        if (c > MAX_COLS)
            c = MAX_COLS;
        return c;
    endfunction

    task automatic restart_tracking();
        cur_row   = '0;
        cur_col   = '0;
        flush_col = '0;
        loaded    = 1'b0;
    endtask

    task automatic add_peak(input int r, input int c);
        peak_t p;
        p.row = ROW_BITS'(r);
        p.col = PEAK_COL_BITS'(c);
        due_peaks.push_back(p);
    endtask

    // one accepted input transaction: decides at most one cell
    task automatic decide_cells(input logic cmd, input sample_t s);
        int      rows;
        int      cols;
        int      r;
        int      c;
        int      k;
        sample_t centre;
        logic    ok;
        rows = rows_eff();
        cols = cols_eff();
        r = int'(cur_row);
        c = int'(cur_col);
        k = int'(flush_col);
        if (cmd == CMD_SAMPLE)
        begin
            if (!loaded && c < cols && r < rows)
            begin
                if (r >= 1)
                begin
                    centre = lower_line[c];
                    ok = (centre >= s);
                    if (r >= 2 && centre < upper_line[c])
                        ok = 1'b0;
                    if (c >= 1 && centre < upper_line[c-1])
                        ok = 1'b0;
                    if (c + 1 < cols && centre < lower_line[c+1])
                        ok = 1'b0;
                    if (ok)
                        add_peak(r - 1, c);
                    upper_line[c] = centre;
                end
                lower_line[c] = s;
                c++;
                if (c >= cols)
                begin
                    c = 0;
                    r++;
                    if (r >= rows)
                    begin
                        r = 0;
                        loaded = 1'b1;
                        flush_col = '0;
                    end
                end
                cur_row = ROW_BITS'(r);
                cur_col = COL_BITS'(c);
            end
        end
        else if (loaded)
        begin
            if (k >= cols)
                restart_tracking();
            else
            begin
                centre = lower_line[k];
                ok = (centre >= upper_line[k]);
                if (k >= 1 && centre < lower_line[k-1])
                    ok = 1'b0;
                if (k + 1 < cols && centre < lower_line[k+1])
                    ok = 1'b0;
                if (ok)
                    add_peak(rows - 1, k);
                k++;
                if (k >= cols)
                    restart_tracking();
                else
                    flush_col = CFG_COLS_BITS'(k);
            end
        end
    endtask

    function automatic void report_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_MISMATCH)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endfunction

    function automatic sample_t pick_value(input int style);
        int v;
        case (style)
            0: return sample_t'($urandom);
            1:
            begin
                v = $urandom_range(0, 4);
                return sample_t'(v - 2);
            end
            default:
            begin
                v = $urandom_range(0, 3);
                case (v)
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return sample_t'(0);
                    default: return sample_t'(-1);
                endcase
            end
        endcase
    endfunction

    function automatic void add_item(input logic cmd, input sample_t value, input logic drain);
        stream_item_t it;
        it.cmd   = cmd;
        it.value = value;
        it.drain = drain;
        item_q.push_back(it);
    endfunction

    // one frame at the current size, optionally cut short, with stray items mixed in
    task automatic queue_frame(input int style, input int cut_at);
        int total;
        int cells;
        int i;
        cells = rows_eff() * cols_eff();
        total = cells + cols_eff();
        if (cut_at > 0 && cut_at < total)
            total = cut_at;
        for (i = 0; i < total; i++)
        begin
            if (i < cells)
            begin
                if ($urandom_range(0, 29) == 0)
                    add_item(CMD_FLUSH, sample_t'($urandom), 1'b0);
                add_item(CMD_SAMPLE, pick_value(style),
                         (i == 0) && ($urandom_range(0, 7) == 0));
            end
            else
            begin
                if ($urandom_range(0, 29) == 0)
                    add_item(CMD_SAMPLE, sample_t'($urandom), 1'b0);
                add_item(CMD_FLUSH, sample_t'($urandom), 1'b0);
            end
            frame_items++;
        end
        if (cut_at == 0 && $urandom_range(0, 9) == 0)
            add_item(CMD_FLUSH, sample_t'($urandom), 1'b0);
    endtask

    task automatic settle();
        while (item_q.size() != 0 || s_axis_tvalid || due_peaks.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAD) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_GRID_ROWS)
            rows_reg = val;
        else
            cols_reg = val[CFG_COLS_BITS-1:0];
        restart_tracking();
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_rows();
        if ($urandom_range(0, 9) == 0)
            return CFG_DATA_BITS'($urandom_range(0, 1));
        return CFG_DATA_BITS'($urandom_range(2, 6));
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] pick_cols();
        if ($urandom_range(0, 9) == 0)
            return CFG_DATA_BITS'($urandom_range(0, 1));
        return CFG_DATA_BITS'($urandom_range(2, 9));
    endfunction

    // input side: one transaction per item, idle gap drawn per item
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_took)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (item_q.size() != 0 && !(item_q[0].drain && due_peaks.size() != 0))
                begin
                    cur_item = item_q.pop_front();
                    s_axis_tuser  <= cur_item.cmd;
                    s_axis_tdata  <= IN_BITS'(cur_item.value);
                    s_axis_tvalid <= 1'b1;
                    gap_left = quiet ? 0 : $urandom_range(0, MAX_IDLE);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output side back-pressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (long_hold_req)
            begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (out_took)
                rx_gap = quiet ? 0 : $urandom_range(0, MAX_IDLE);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        peak_t want;
        if (!rst_n)
        begin
            in_took  = 1'b0;
            out_took = 1'b0;
        end
        else
        begin
            in_took  = s_axis_tvalid && s_axis_tready;
            out_took = m_axis_tvalid && m_axis_tready;
            if (in_took)
                decide_cells(s_axis_tuser, sample_t'(s_axis_tdata[SAMPLE_BITS-1:0]));
            if (out_took)
            begin
                if (due_peaks.size() == 0)
                    report_fail($sformatf("unexpected peak row %0d col %0d",
                                          m_axis_tdata[ROW_BITS-1:0],
                                          m_axis_tdata[OUT_RAW_BITS-1:ROW_BITS]));
                else
                begin
                    want = due_peaks.pop_front();
                    if (m_axis_tdata[ROW_BITS-1:0] !== want.row ||
                        m_axis_tdata[OUT_RAW_BITS-1:ROW_BITS] !== want.col)
                        report_fail($sformatf("peak expected row %0d col %0d, got row %0d col %0d",
                                              want.row, want.col,
                                              m_axis_tdata[ROW_BITS-1:0],
                                              m_axis_tdata[OUT_RAW_BITS-1:ROW_BITS]));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        int choice;
        int frames;
        int f;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = CMD_SAMPLE;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_GRID_ROWS;
        cfg_data      = '0;
        rows_reg      = ROW_BITS'(2);
        cols_reg      = CFG_COLS_BITS'(2);
        restart_tracking();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: default 2x2 with stray flush, extremes, stray sample, late flush
        add_item(CMD_FLUSH, SAMPLE_MIN, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MAX, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MIN, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MIN, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MAX, 1'b0);
        add_item(CMD_SAMPLE, sample_t'(5), 1'b0);
        add_item(CMD_FLUSH, SAMPLE_MAX, 1'b0);
        add_item(CMD_FLUSH, sample_t'(0), 1'b0);
        add_item(CMD_FLUSH, sample_t'(-1), 1'b0);
        // plateau, every cell a peak
        add_item(CMD_SAMPLE, sample_t'(7), 1'b1);
        add_item(CMD_SAMPLE, sample_t'(7), 1'b0);
        add_item(CMD_SAMPLE, sample_t'(7), 1'b0);
        add_item(CMD_SAMPLE, sample_t'(7), 1'b0);
        add_item(CMD_FLUSH, sample_t'(0), 1'b0);
        add_item(CMD_FLUSH, sample_t'(0), 1'b0);
        // partial frame, aborted by the next register write
        add_item(CMD_SAMPLE, sample_t'(-1), 1'b0);
        add_item(CMD_SAMPLE, sample_t'(0), 1'b0);
        add_item(CMD_SAMPLE, sample_t'(1), 1'b0);
        settle();
        write_reg(REG_GRID_ROWS, CFG_DATA_BITS'(3));
        write_reg(REG_GRID_COLS, CFG_DATA_BITS'(3));
        add_item(CMD_SAMPLE, SAMPLE_MIN, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MAX, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MIN, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MAX, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MAX, 1'b0);
        add_item(CMD_SAMPLE, SAMPLE_MAX, 1'b0);
        queue_frame(1, 4);
        settle();

        // output held off while input keeps coming
        write_reg(REG_GRID_ROWS, CFG_DATA_BITS'(6));
        write_reg(REG_GRID_COLS, CFG_DATA_BITS'(8));
        quiet = 1'b1;
        long_hold_req = 1'b1;
        frame_items = 0;
        for (f = 0; f < 3; f++)
            queue_frame(1, 0);

        while (frame_items < RANDOM_ITEMS - WIDE_CUT - TAIL_ITEMS)
        begin
            settle();
            choice = $urandom_range(0, 2);
            if (choice != 1)
                write_reg(REG_GRID_ROWS, pick_rows());
            if (choice != 0)
                write_reg(REG_GRID_COLS, pick_cols());
            quiet = ($urandom_range(0, 3) == 0);
            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++)
                queue_frame($urandom_range(0, 2),
                            ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : 0);
        end

        // widest grid, bit 11 of the column value is dropped and the size clamps;
        // cut once the first row has wrapped, aborted by the next register write
        settle();
        write_reg(REG_GRID_ROWS, CFG_DATA_BITS'(2));
        write_reg(REG_GRID_COLS, {CFG_DATA_BITS{1'b1}});
        quiet = 1'b1;
        queue_frame($urandom_range(0, 2), WIDE_CUT);

        // tallest grid, started and then aborted
        settle();
        write_reg(REG_GRID_ROWS, {CFG_DATA_BITS{1'b1}});
        write_reg(REG_GRID_COLS, CFG_DATA_BITS'(2));
        quiet = 1'b0;
        queue_frame(0, 40);
        settle();
        write_reg(REG_GRID_ROWS, CFG_DATA_BITS'(3));
        queue_frame(2, 0);

        settle();
        repeat (END_PAD) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
